@@ rtl/core/qnn_pkg.sv @@
// Package for the quad Newell normal block: shared constants and the queue status type.
// No dependencies.
package qnn_pkg;

    localparam int COMPONENTS        = 3;
    localparam int CORNERS           = 4;
    localparam int COORD_WIDTH_DEF   = 32;
    localparam int QUEUE_DEPTH_DEF   = 4;
    localparam int UNIT_FRAC         = 30;   // Q1.30 output, top magnitude bit lands here
    localparam int MAG_BITS          = 31;   // normalized magnitude width
    localparam int SUMSQ_BITS        = 64;
    localparam int ROOT_BITS         = 32;
    localparam int QUOT_BITS         = 31;
    localparam int GROUP_BITS        = 8;    // leading-one search group size

    typedef struct packed {
        logic not_empty;
        logic can_push;
    } t_queue_stat;

endpackage

@@ rtl/core/qnn_if.sv @@
// Channel interfaces for the quad Newell normal block: corner words in, normal words out.
// Depends on nothing.
interface qnn_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] a_x, a_y, a_z;
    logic signed [31:0] b_x, b_y, b_z;
    logic signed [31:0] c_x, c_y, c_z;
    logic signed [31:0] d_x, d_y, d_z;

    modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                    d_x, d_y, d_z, input ready);
    modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                    d_x, d_y, d_z, output ready);
endinterface

interface qnn_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] normal_x, normal_y, normal_z;
    logic               degenerate;

    modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

@@ rtl/core/qnn_front.sv @@
// Front pipeline: edge differences and sums, products, Newell sums, sign and magnitude.
// Depends on qnn_pkg and qnn_in_if.
module qnn_front #(
    parameter int COORD_WIDTH = qnn_pkg::COORD_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    qnn_in_if.sink                                 i_in,
    input  qnn_pkg::t_queue_stat                   i_qstat,
    output logic                                   o_push,
    output logic [qnn_pkg::COMPONENTS*(2*COORD_WIDTH+4)+qnn_pkg::COMPONENTS-1:0] o_word
);
    localparam int CW = COORD_WIDTH;
    localparam int NW = 2 * CW + 4;
    localparam int NC = qnn_pkg::COMPONENTS;
    localparam int NV = qnn_pkg::CORNERS;

    logic                 en;
    logic                 r_v [5];
    logic signed [CW-1:0] crd [NV][NC];
    logic signed [CW:0]   n_d [NC][NV];
    logic signed [CW:0]   n_t [NC][NV];
    logic signed [CW:0]   r_d [NC][NV];
    logic signed [CW:0]   r_t [NC][NV];
    logic signed [2*CW+1:0] r_p [NC][NV];
    logic signed [NW-1:0] r_s2 [NC][2];
    logic signed [NW-1:0] r_n [NC];
    logic [NW-1:0]        r_mag [NC];
    logic [NC-1:0]        r_neg;

    // stall only while the queue has no room for the last stage's word
    assign en          = i_qstat.can_push || !r_v[4];
    assign i_in.ready  = en;
    assign o_push      = r_v[4] && en;

    assign crd[0][0] = i_in.a_x[CW-1:0];
    assign crd[0][1] = i_in.a_y[CW-1:0];
    assign crd[0][2] = i_in.a_z[CW-1:0];
    assign crd[1][0] = i_in.b_x[CW-1:0];
    assign crd[1][1] = i_in.b_y[CW-1:0];
    assign crd[1][2] = i_in.b_z[CW-1:0];
    assign crd[2][0] = i_in.c_x[CW-1:0];
    assign crd[2][1] = i_in.c_y[CW-1:0];
    assign crd[2][2] = i_in.c_z[CW-1:0];
    assign crd[3][0] = i_in.d_x[CW-1:0];
    assign crd[3][1] = i_in.d_y[CW-1:0];
    assign crd[3][2] = i_in.d_z[CW-1:0];

    always_comb begin
        for (int k = 0; k < NC; k++) begin
            for (int i = 0; i < NV; i++) begin
                n_d[k][i] = (CW+1)'(crd[i][(k+1) % NC]) - (CW+1)'(crd[(i+1) % NV][(k+1) % NC]);
                n_t[k][i] = (CW+1)'(crd[i][(k+2) % NC]) + (CW+1)'(crd[(i+1) % NV][(k+2) % NC]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 5; s++) r_v[s] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_in.valid;
            for (int s = 1; s < 5; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NC; k++) begin
                for (int i = 0; i < NV; i++) begin
                    r_d[k][i] <= n_d[k][i];
                    r_t[k][i] <= n_t[k][i];
                    r_p[k][i] <= r_d[k][i] * r_t[k][i];
                end
                for (int h = 0; h < 2; h++) begin
                    r_s2[k][h] <= NW'(r_p[k][2*h]) + NW'(r_p[k][2*h+1]);
                end
                r_n[k]   <= r_s2[k][0] + r_s2[k][1];
                r_neg[k] <= r_n[k][NW-1];
                r_mag[k] <= r_n[k][NW-1] ? NW'(-r_n[k]) : NW'(r_n[k]);
            end
        end
    end

    assign o_word = {r_neg, r_mag[2], r_mag[1], r_mag[0]};

endmodule

@@ rtl/core/qnn_queue.sv @@
// Short register queue between the front and back pipelines.
// Depends on qnn_pkg.
module qnn_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = qnn_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [WIDTH-1:0]     i_data,
    input  logic                 i_pop,
    output logic [WIDTH-1:0]     o_data,
    output qnn_pkg::t_queue_stat o_stat
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [PW:0]      r_cnt;
    logic             pop_ok;

    assign pop_ok          = i_pop && (r_cnt != '0);
    assign o_stat.not_empty = (r_cnt != '0);
    assign o_stat.can_push  = (r_cnt != (PW+1)'(DEPTH)) || pop_ok;
    assign o_data           = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == PW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (pop_ok) r_rp <= (r_rp == PW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule

@@ rtl/core/qnn_back.sv @@
// Back pipeline: leading-one search, normalizing shift, squares, pipelined square root,
// three pipelined dividers and the output register. Depends on qnn_pkg and qnn_out_if.
module qnn_back #(
    parameter int COORD_WIDTH = qnn_pkg::COORD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  qnn_pkg::t_queue_stat i_qstat,
    input  logic [qnn_pkg::COMPONENTS*(2*COORD_WIDTH+4)+qnn_pkg::COMPONENTS-1:0] i_word,
    output logic                 o_pop,
    qnn_out_if.source            o_out
);
    localparam int NW = 2 * COORD_WIDTH + 4;
    localparam int NC = qnn_pkg::COMPONENTS;
    localparam int TW = $clog2(NW);
    localparam int GB = qnn_pkg::GROUP_BITS;
    localparam int NG = (NW + GB - 1) / GB;
    localparam int MB = qnn_pkg::MAG_BITS;
    localparam int UF = qnn_pkg::UNIT_FRAC;
    localparam int SB = qnn_pkg::SUMSQ_BITS;
    localparam int RB = qnn_pkg::ROOT_BITS;
    localparam int QB = qnn_pkg::QUOT_BITS;

    logic en;
    assign en    = !o_out.valid || o_out.ready;
    assign o_pop = en && i_qstat.not_empty;

    // stage 0: queue word
    logic            r_v0;
    logic [NW-1:0]   r_mag0 [NC];
    logic [NC-1:0]   r_neg0;
    // stage 1: group flags of the leading-one search
    logic            r_v1;
    logic [NW-1:0]   r_mag1 [NC];
    logic [NC-1:0]   r_neg1;
    logic [NG-1:0]   r_gnz;
    logic [2:0]      r_gpos [NG];
    logic [NG-1:0]   n_gnz;
    logic [2:0]      n_gpos [NG];
    logic [NW-1:0]   orv;
    // stage 2: top bit
    logic            r_v2;
    logic [NW-1:0]   r_mag2 [NC];
    logic [NC-1:0]   r_neg2;
    logic [TW-1:0]   r_top, n_top;
    logic            r_deg2;
    // stage 3: normalized magnitudes
    logic            r_v3;
    logic [MB-1:0]   r_m3 [NC];
    logic [NC-1:0]   r_neg3;
    logic            r_deg3;
    // stage 4: squares
    logic            r_v4;
    logic [MB-1:0]   r_m4 [NC];
    logic [2*MB-1:0] r_sq4 [NC];
    logic [NC-1:0]   r_neg4;
    logic            r_deg4;

    // square root stages, index 0 is the sum of squares
    logic            r_sv [RB+1];
    logic [SB-1:0]   r_sn [RB+1];
    logic [SB-1:0]   r_sr [RB+1];
    logic [MB-1:0]   r_sm [RB+1][NC];
    logic [NC-1:0]   r_sneg [RB+1];
    logic            r_sdeg [RB+1];

    // divider stages, index 0 holds the dividend and divisor
    logic            r_dv [QB+1];
    logic [SB-1:0]   r_drem [QB+1][NC];
    logic [QB-1:0]   r_dq [QB+1][NC];
    logic [RB-1:0]   r_dS [QB+1];
    logic [NC-1:0]   r_dneg [QB+1];
    logic            r_ddeg [QB+1];

    logic [RB-1:0]   root;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0; r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
            for (int s = 0; s <= RB; s++) r_sv[s] <= 1'b0;
            for (int s = 0; s <= QB; s++) r_dv[s] <= 1'b0;
            o_out.valid <= 1'b0;
        end else if (en) begin
            r_v0 <= i_qstat.not_empty;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_sv[0] <= r_v4;
            for (int s = 1; s <= RB; s++) r_sv[s] <= r_sv[s-1];
            r_dv[0] <= r_sv[RB];
            for (int s = 1; s <= QB; s++) r_dv[s] <= r_dv[s-1];
            o_out.valid <= r_dv[QB];
        end
    end

    always_comb begin
        orv = r_mag0[0] | r_mag0[1] | r_mag0[2];
        for (int g = 0; g < NG; g++) begin
            n_gnz[g]  = 1'b0;
            n_gpos[g] = '0;
            for (int b = 0; b < GB; b++) begin
                if ((g*GB + b < NW) && orv[(g*GB + b) % NW]) begin
                    n_gnz[g]  = 1'b1;
                    n_gpos[g] = 3'(b);
                end
            end
        end
    end

    always_comb begin
        n_top = '0;
        for (int g = 0; g < NG; g++) begin
            if (r_gnz[g]) n_top = TW'(g*GB) + TW'(r_gpos[g]);
        end
    end

    assign root = (r_sr[RB][RB-1:0] == '0) ? RB'(1) : r_sr[RB][RB-1:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NC; k++) r_mag0[k] <= i_word[k*NW +: NW];
            r_neg0 <= i_word[NC*NW +: NC];

            r_mag1 <= r_mag0;
            r_neg1 <= r_neg0;
            r_gnz  <= n_gnz;
            r_gpos <= n_gpos;

            r_mag2 <= r_mag1;
            r_neg2 <= r_neg1;
            r_top  <= n_top;
            r_deg2 <= (r_gnz == '0);

            for (int k = 0; k < NC; k++) begin
                if (r_top > TW'(UF))
                    r_m3[k] <= MB'(r_mag2[k] >> (r_top - TW'(UF)));
                else
                    r_m3[k] <= MB'(r_mag2[k] << (TW'(UF) - r_top));
            end
            r_neg3 <= r_neg2;
            r_deg3 <= r_deg2;

            for (int k = 0; k < NC; k++) r_sq4[k] <= r_m3[k] * r_m3[k];
            r_m4   <= r_m3;
            r_neg4 <= r_neg3;
            r_deg4 <= r_deg3;

            r_sn[0]   <= SB'(r_sq4[0]) + SB'(r_sq4[1]) + SB'(r_sq4[2]);
            r_sr[0]   <= '0;
            r_sm[0]   <= r_m4;
            r_sneg[0] <= r_neg4;
            r_sdeg[0] <= r_deg4;

            for (int s = 0; s < RB; s++) begin
                // one result bit per stage, probe bit 4^(31-s)
                if (r_sn[s] >= r_sr[s] + (SB'(1) << (2*(RB-1-s)))) begin
                    r_sn[s+1] <= r_sn[s] - (r_sr[s] + (SB'(1) << (2*(RB-1-s))));
                    r_sr[s+1] <= (r_sr[s] >> 1) + (SB'(1) << (2*(RB-1-s)));
                end else begin
                    r_sn[s+1] <= r_sn[s];
                    r_sr[s+1] <= r_sr[s] >> 1;
                end
                r_sm[s+1]   <= r_sm[s];
                r_sneg[s+1] <= r_sneg[s];
                r_sdeg[s+1] <= r_sdeg[s];
            end

            for (int k = 0; k < NC; k++) begin
                r_drem[0][k] <= SB'(r_sm[RB][k]) << UF;
                r_dq[0][k]   <= '0;
            end
            r_dS[0]   <= root;
            r_dneg[0] <= r_sneg[RB];
            r_ddeg[0] <= r_sdeg[RB];

            for (int s = 0; s < QB; s++) begin
                for (int k = 0; k < NC; k++) begin
                    if (r_drem[s][k] >= (SB'(r_dS[s]) << (QB-1-s))) begin
                        r_drem[s+1][k] <= r_drem[s][k] - (SB'(r_dS[s]) << (QB-1-s));
                        r_dq[s+1][k]   <= r_dq[s][k] | (QB'(1) << (QB-1-s));
                    end else begin
                        r_drem[s+1][k] <= r_drem[s][k];
                        r_dq[s+1][k]   <= r_dq[s][k];
                    end
                end
                r_dS[s+1]   <= r_dS[s];
                r_dneg[s+1] <= r_dneg[s];
                r_ddeg[s+1] <= r_ddeg[s];
            end

            o_out.degenerate <= r_ddeg[QB];
            o_out.normal_x <= r_ddeg[QB] ? '0 :
                (r_dneg[QB][0] ? -32'(r_dq[QB][0]) : 32'(r_dq[QB][0]));
            o_out.normal_y <= r_ddeg[QB] ? '0 :
                (r_dneg[QB][1] ? -32'(r_dq[QB][1]) : 32'(r_dq[QB][1]));
            o_out.normal_z <= r_ddeg[QB] ? '0 :
                (r_dneg[QB][2] ? -32'(r_dq[QB][2]) : 32'(r_dq[QB][2]));
        end
    end

endmodule

@@ rtl/core/quad_normal_newell.sv @@
// Top level of the quad Newell normal block: front pipeline, queue, back pipeline.
// Depends on qnn_pkg, qnn_if, qnn_front, qnn_queue and qnn_back.
//
//  channel  dir  payload                                      handshake
//  i_in     in   a_x..d_z, 12 x signed Q15.16                 valid/ready
//  o_out    out  normal_x/y/z signed Q1.30, degenerate        valid/ready
//
// One word per cycle sustained while o_out.ready stays high; every stage is fully pipelined.
// 77 register stages from the accepting edge to the output:
// 5 front stages, the queue, 5 normalize stages, a sum stage and 32 square root
// stages (one root bit each), a dividend stage and 31 divider stages, output register.
// Reset clears valid bits and queue pointers only; no clearing pass.
// The back pipeline stalls as a whole on o_out.ready; the front stalls only when
// the queue is full, so short output stalls do not reach i_in.
module quad_normal_newell #(
    parameter int COORD_WIDTH = qnn_pkg::COORD_WIDTH_DEF,
    parameter int QUEUE_DEPTH = qnn_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qnn_in_if.sink    i_in,
    qnn_out_if.source o_out
);
    localparam int QW = qnn_pkg::COMPONENTS * (2 * COORD_WIDTH + 4) + qnn_pkg::COMPONENTS;

    qnn_pkg::t_queue_stat qstat;
    logic                 push, pop;
    logic [QW-1:0]        fwd_word, bk_word;

    qnn_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_qstat (qstat),
        .o_push  (push),
        .o_word  (fwd_word)
    );

    qnn_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (fwd_word),
        .i_pop   (pop),
        .o_data  (bk_word),
        .o_stat  (qstat)
    );

    qnn_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (qstat),
        .i_word  (bk_word),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

@@ tb/qnn_tb_scoreboard.sv @@
// Scoreboard class for the quad Newell normal testbench: unit-normal predictor and result check.
// Depends on nothing; the testbench top instantiates it.
`timescale 1ns / 1ps

typedef struct {
    logic signed [31:0] nx, ny, nz;
    logic               degen;
} normal_word_t;

class normal_scoreboard;
    normal_word_t pending[$];
    int           errors;

    function new();
        errors = 0;
    endfunction

    static function logic [63:0] root64(logic [63:0] n);
        logic [63:0] res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // corners c[corner][axis], axis 0..2 = x,y,z
    static function normal_word_t unit_normal(logic signed [31:0] c[4][3]);
        normal_word_t r;
        logic signed [71:0] acc[3];
        logic [71:0]        mag[3];
        logic               neg[3];
        logic [63:0]        m[3];
        logic [63:0]        sumsq, s, q;
        logic signed [71:0] d, t;
        int                 top, u, w, j;
        top = -1;
        for (int k = 0; k < 3; k++) begin
            u = (k + 1) % 3;
            w = (k + 2) % 3;
            acc[k] = 0;
            for (int i = 0; i < 4; i++) begin
                j = (i + 1) % 4;
                d = 72'(c[i][u]) - 72'(c[j][u]);
                t = 72'(c[i][w]) + 72'(c[j][w]);
                acc[k] = acc[k] + d * t;
            end
            neg[k] = acc[k] < 0;
            mag[k] = neg[k] ? -acc[k] : acc[k];
            for (int b = 71; b >= 0; b--)
                if (mag[k][b]) begin
                    if (b > top) top = b;
                    break;
                end
        end
        r.degen = (top < 0);
        r.nx = 0; r.ny = 0; r.nz = 0;
        if (top < 0) return r;
        sumsq = 0;
        for (int k = 0; k < 3; k++) begin
            if (top > 30) m[k] = 64'(mag[k] >> (top - 30));
            else          m[k] = 64'(mag[k] << (30 - top));
            m[k]  = m[k] & 64'h7FFF_FFFF;
            sumsq = sumsq + m[k] * m[k];
        end
        s = root64(sumsq);
        if (s == 0) s = 1;
        for (int k = 0; k < 3; k++) begin
            q = (m[k] << 30) / s;
            if (neg[k]) q = -q;
            if (k == 0) r.nx = q[31:0];
            else if (k == 1) r.ny = q[31:0];
            else r.nz = q[31:0];
        end
        return r;
    endfunction

    function void note_quad(logic signed [31:0] c[4][3]);
        pending.push_back(unit_normal(c));
    endfunction

    function void check_normal(normal_word_t got);
        normal_word_t e;
        if (pending.size() == 0) begin
            $error("normal word with nothing expected");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.nx !== e.nx) begin
            $error("normal_x expected %0d got %0d", e.nx, got.nx); errors++;
        end
        if (got.ny !== e.ny) begin
            $error("normal_y expected %0d got %0d", e.ny, got.ny); errors++;
        end
        if (got.nz !== e.nz) begin
            $error("normal_z expected %0d got %0d", e.nz, got.nz); errors++;
        end
        if (got.degen !== e.degen) begin
            $error("degenerate expected %0b got %0b", e.degen, got.degen); errors++;
        end
    endfunction
endclass

@@ tb/testbench.sv @@
// Top of the quad Newell normal testbench: drives corner words, checks normal words.
// Depends on qnn_pkg, qnn_if, quad_normal_newell and qnn_tb_scoreboard.
`timescale 1ns / 1ps

module testbench;
    logic i_clk = 0;
    logic i_rst_n = 0;
    bit   calm = 0;      // no idling in the last part

    qnn_in_if  in_ch();
    qnn_out_if out_ch();

    quad_normal_newell dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch));

    normal_scoreboard sb = new();

    always #10 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("testbench: errors");
        $finish;
    end

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 200)) - 100);
            default: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
        endcase
    endfunction

    task automatic send_quad(logic signed [31:0] c[4][3]);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            in_ch.valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.a_x <= c[0][0]; in_ch.a_y <= c[0][1]; in_ch.a_z <= c[0][2];
        in_ch.b_x <= c[1][0]; in_ch.b_y <= c[1][1]; in_ch.b_z <= c[1][2];
        in_ch.c_x <= c[2][0]; in_ch.c_y <= c[2][1]; in_ch.c_z <= c[2][2];
        in_ch.d_x <= c[3][0]; in_ch.d_y <= c[3][1]; in_ch.d_z <= c[3][2];
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_quad(c);
        @(negedge i_clk);
    endtask

    // output side: random stall bursts, sample at rising edge
    initial begin
        int stall;
        out_ch.ready = 0;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) stall--;
            else if (!calm && $urandom_range(0, 4) == 0) stall = $urandom_range(1, 4);
            out_ch.ready <= (stall == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            normal_word_t got;
            got.nx = out_ch.normal_x; got.ny = out_ch.normal_y;
            got.nz = out_ch.normal_z; got.degen = out_ch.degenerate;
            sb.check_normal(got);
        end
    end

    initial begin
        logic signed [31:0] c[4][3];
        int mode, waited;
        in_ch.valid = 0;
        {in_ch.a_x, in_ch.a_y, in_ch.a_z, in_ch.b_x, in_ch.b_y, in_ch.b_z} = '0;
        {in_ch.c_x, in_ch.c_y, in_ch.c_z, in_ch.d_x, in_ch.d_y, in_ch.d_z} = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // all corners equal: zero normal
        foreach (c[i, k]) c[i][k] = 32'h0001_0000;
        send_quad(c);
        // collinear corners: zero normal
        foreach (c[i, k]) c[i][k] = 32'(i * 65536);
        send_quad(c);
        // unit square in xy plane, both windings
        c = '{'{0, 0, 0}, '{65536, 0, 0}, '{65536, 65536, 0}, '{0, 65536, 0}};
        send_quad(c);
        c = '{'{0, 65536, 0}, '{65536, 65536, 0}, '{65536, 0, 0}, '{0, 0, 0}};
        send_quad(c);
        // smallest nonzero normal
        c = '{'{0, 0, 0}, '{1, 0, 0}, '{0, 1, 0}, '{0, 0, 0}};
        send_quad(c);
        // extremes of the coordinate range
        for (int n = 0; n < 12; n++) begin
            foreach (c[i, k]) c[i][k] = rand_coord(1);
            if (n == 0) foreach (c[i, k]) c[i][k] = (i[0] ^ k[0]) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            if (n == 1) foreach (c[i, k]) c[i][k] = (i == k) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            send_quad(c);
        end

        for (int n = 0; n < 830; n++) begin
            if (n == 700) calm = 1;
            mode = $urandom_range(0, 3);
            foreach (c[i, k]) c[i][k] = rand_coord($urandom_range(0, 7) == 0 ? 1 : mode);
            // occasionally a flat or repeated-corner quad
            if ($urandom_range(0, 15) == 0) foreach (c[i, k]) c[i][2] = c[0][2];
            if ($urandom_range(0, 15) == 0) c[3] = c[2];
            send_quad(c);
        end
        in_ch.valid <= 0;

        waited = 0;
        while (sb.pending.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (200) @(posedge i_clk);
        if (sb.pending.size() == 0 && sb.errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
